// File: hdl/fp8_blockwise_scaled_dot_top_macros.svh
// Assertion helpers for the dot-product engine.
`ifndef FP8_BLOCKWISE_SCALED_DOT_TOP_MACROS_SVH
`define FP8_BLOCKWISE_SCALED_DOT_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define FBSD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fbsd assertion failed");

// Next-cycle implication.
`define FBSD_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fbsd assertion failed");

`endif

// File: hdl/fbsd_pkg.sv
package fbsd_pkg;

    localparam int MANT_W = 48;
    localparam int EXP_W  = 11;

    localparam logic [1:0] FMT_F16  = 2'd0;
    localparam logic [1:0] FMT_BF16 = 2'd1;
    localparam logic [1:0] FMT_F32  = 2'd2;

    localparam logic [31:0] F32_QNAN = 32'h7fc0_0000;
    localparam logic [15:0] F16_QNAN = 16'h7e00;
    localparam logic [15:0] BF16_QNAN = 16'h7fc0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_BSUM,
        ST_SCALE,
        ST_RSUM,
        ST_OUT
    } state_t;

    typedef enum logic {
        FPU_MUL,
        FPU_ADD
    } fpu_op_t;

    typedef enum logic [1:0] {
        KIND_FIN,
        KIND_ZERO,
        KIND_INF,
        KIND_NAN
    } kind_t;

    typedef struct packed {
        logic    start;
        fpu_op_t op;
    } fpu_req_t;

    // value = mant * 2^lsb_exp
    typedef struct packed {
        kind_t                   kind;
        logic                    sign;
        logic signed [EXP_W-1:0] lsb_exp;
        logic [MANT_W-1:0]       mant;
    } fpu_s1_t;

    typedef struct packed {
        kind_t                   kind;
        logic                    sign;
        logic [8:0]              field;
        logic signed [EXP_W-1:0] shift;
        logic [MANT_W-1:0]       mant;
    } fpu_s2_t;

    function automatic logic [31:0] widen_f16(input logic [15:0] h);
        logic       s;
        logic [4:0] e;
        logic [9:0] m;
        logic [3:0] p;
        logic [23:0] n;
        logic [31:0] r;
        s = h[15];
        e = h[14:10];
        m = h[9:0];
        p = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                p = 4'(i);
            end
        end
        n = {14'd0, m} << (5'd23 - {1'b0, p});
        if (e == 5'h1f) begin
            r = {s, 8'hff, m, 13'd0};
        end else if (e == 5'd0) begin
            if (m == 10'd0) begin
                r = {s, 31'd0};
            end else begin
                r = {s, 8'(8'd103 + {4'd0, p}), n[22:0]};
            end
        end else begin
            r = {s, 3'd0, e, 23'd0} + {1'b0, 8'd112, 23'd0} + {9'd0, m, 13'd0};
        end
        return r;
    endfunction

    function automatic logic [31:0] widen_act(input logic [31:0] a, input logic [1:0] fmt);
        logic [31:0] r;
        if (fmt == FMT_F16) begin
            r = widen_f16(a[15:0]);
        end else if (fmt == FMT_BF16) begin
            r = {a[15:0], 16'd0};
        end else begin
            r = a;
        end
        return r;
    endfunction

    function automatic logic [31:0] decode_weight(input logic [7:0] b);
        logic        s;
        logic [3:0]  e;
        logic [2:0]  m;
        logic [31:0] r;
        s = b[7];
        e = b[6:3];
        m = b[2:0];
        if (e == 4'hf && m == 3'h7) begin
            r = F32_QNAN;
        end else if (e == 4'd0) begin
            unique case (m)
                3'd0: r = {s, 31'd0};
                3'd1: r = {s, 8'd118, 23'h000000};
                3'd2: r = {s, 8'd119, 23'h000000};
                3'd3: r = {s, 8'd119, 23'h400000};
                3'd4: r = {s, 8'd120, 23'h000000};
                3'd5: r = {s, 8'd120, 23'h200000};
                3'd6: r = {s, 8'd120, 23'h400000};
                3'd7: r = {s, 8'd120, 23'h600000};
                default: r = {s, 31'd0};
            endcase
        end else begin
            r = {s, 8'({4'd0, e} + 8'd120), m, 20'd0};
        end
        return r;
    endfunction

    function automatic logic [15:0] narrow_f16(input logic [31:0] x);
        logic              s;
        logic [7:0]        e;
        logic [22:0]       m;
        logic signed [9:0] e16;
        logic [9:0]        shf;
        logic [23:0]       mant;
        logic [23:0]       hq;
        logic [23:0]       rem;
        logic [23:0]       half;
        logic [15:0]       h;
        logic [15:0]       r;
        s = x[31];
        e = x[30:23];
        m = x[22:0];
        e16 = $signed({2'b00, e}) - 10'sd112;
        shf = 10'(10'sd14 - e16);
        mant = {1'b1, m};
        hq = 24'd0;
        rem = 24'd0;
        half = 24'd0;
        h = 16'd0;
        if (e == 8'hff) begin
            r = (m != 23'd0) ? F16_QNAN : {s, 15'h7c00};
        end else if (e == 8'd0) begin
            r = {s, 15'd0};
        end else if (e16 >= 10'sd31) begin
            r = {s, 15'h7c00};
        end else if (e16 <= 10'sd0) begin
            if (shf > 10'd24) begin
                r = {s, 15'd0};
            end else begin
                hq = mant >> shf[4:0];
                rem = mant & ((24'd1 << shf[4:0]) - 24'd1);
                half = 24'd1 << (shf[4:0] - 5'd1);
                h = hq[15:0];
                if (rem > half || (rem == half && hq[0])) begin
                    h = h + 16'd1;
                end
                r = {s, 15'd0} | h;
            end
        end else begin
            h = {1'b0, e16[4:0], m[22:13]};
            if (m[12:0] > 13'h1000 || (m[12:0] == 13'h1000 && h[0])) begin
                h = h + 16'd1;
            end
            r = {s, 15'd0} | h;
        end
        return r;
    endfunction

    function automatic logic [15:0] narrow_bf16(input logic [31:0] x);
        logic [31:0] t;
        logic [15:0] r;
        t = x + 32'h0000_7fff + {31'd0, x[16]};
        if (x[30:0] > 31'h7f80_0000) begin
            r = BF16_QNAN;
        end else begin
            r = t[31:16];
        end
        return r;
    endfunction

endpackage

// File: hdl/fp8_blockwise_scaled_dot_top.sv
// Channel   | Ports                                   | Direction
// ----------+-----------------------------------------+----------
// input     | s_valid/s_ready, s_act_value, ...       | in
// result    | m_valid/m_ready, m_result_value         | out
// config    | cfg_wr_en, cfg_wr_data                  | in
//
// One shared fp32 mul/add unit; each operation is an issue plus 3 stages.
// Plain item: product, block add. Block or row end: also scale, row add.
// Row end: output, after any wait for the previous result to be taken by m_ready.
// aresetn is synchronous, active low; clears both sums and sets fp32 format.
// s_ready is high only between transactions.
`include "fp8_blockwise_scaled_dot_top_macros.svh"

module fp8_blockwise_scaled_dot_top
    import fbsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_act_value,
    input  logic [7:0]  s_weight_byte,
    input  logic [31:0] s_block_scale,
    input  logic        s_block_end,
    input  logic        s_row_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_value
);

    state_t      state_reg, state_next;
    logic        issued_reg, issued_next;
    logic [1:0]  fmt_reg;
    logic [31:0] act_reg, act_next;
    logic [31:0] wgt_reg, wgt_next;
    logic [31:0] scale_reg, scale_next;
    logic        bend_reg, bend_next;
    logic        rend_reg, rend_next;
    logic [31:0] tmp_reg, tmp_next;
    logic [31:0] block_sum_reg, block_sum_next;
    logic [31:0] row_sum_reg, row_sum_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_result_reg, m_result_next;
    logic        out_load;
    logic        in_op;
    fpu_req_t    fpu_req;
    logic [31:0] fpu_a, fpu_b, fpu_res;
    logic        fpu_done;

    fbsd_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .opa     (fpu_a),
        .opb     (fpu_b),
        .done    (fpu_done),
        .result  (fpu_res)
    );

    assign in_op = (state_reg == ST_PROD || state_reg == ST_BSUM || state_reg == ST_SCALE
                    || state_reg == ST_RSUM);

    always_comb begin
        state_next = state_reg;
        issued_next = issued_reg;
        act_next = act_reg;
        wgt_next = wgt_reg;
        scale_next = scale_reg;
        bend_next = bend_reg;
        rend_next = rend_reg;
        tmp_next = tmp_reg;
        block_sum_next = block_sum_reg;
        row_sum_next = row_sum_reg;
        m_result_next = m_result_reg;
        out_load = 1'b0;
        s_ready = 1'b0;
        fpu_req.start = 1'b0;
        fpu_req.op = FPU_MUL;
        fpu_a = act_reg;
        fpu_b = wgt_reg;

        if (in_op) begin
            fpu_req.start = !issued_reg;
            issued_next = !fpu_done;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    act_next = widen_act(s_act_value, fmt_reg);
                    wgt_next = decode_weight(s_weight_byte);
                    scale_next = s_block_scale;
                    bend_next = s_block_end;
                    rend_next = s_row_end;
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                if (fpu_done) begin
                    tmp_next = fpu_res;
                    state_next = ST_BSUM;
                end
            end
            ST_BSUM: begin
                fpu_req.op = FPU_ADD;
                fpu_a = block_sum_reg;
                fpu_b = tmp_reg;
                if (fpu_done) begin
                    block_sum_next = fpu_res;
                    state_next = (bend_reg || rend_reg) ? ST_SCALE : ST_IDLE;
                end
            end
            ST_SCALE: begin
                fpu_a = scale_reg;
                fpu_b = block_sum_reg;
                if (fpu_done) begin
                    tmp_next = fpu_res;
                    block_sum_next = 32'd0;
                    state_next = ST_RSUM;
                end
            end
            ST_RSUM: begin
                fpu_req.op = FPU_ADD;
                fpu_a = row_sum_reg;
                fpu_b = tmp_reg;
                if (fpu_done) begin
                    row_sum_next = fpu_res;
                    state_next = rend_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load = 1'b1;
                    if (fmt_reg == FMT_F16) begin
                        m_result_next = {16'd0, narrow_f16(row_sum_reg)};
                    end else if (fmt_reg == FMT_BF16) begin
                        m_result_next = {16'd0, narrow_bf16(row_sum_reg)};
                    end else if (row_sum_reg[30:0] > 31'h7f80_0000) begin
                        m_result_next = F32_QNAN;
                    end else begin
                        m_result_next = row_sum_reg;
                    end
                    row_sum_next = 32'd0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        m_valid_next = out_load | (m_valid_reg & !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            issued_reg <= 1'b0;
            fmt_reg <= FMT_F32;
            block_sum_reg <= 32'd0;
            row_sum_reg <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            issued_reg <= issued_next;
            if (cfg_wr_en) begin
                fmt_reg <= cfg_wr_data;
            end
            block_sum_reg <= block_sum_next;
            row_sum_reg <= row_sum_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg <= act_next;
        wgt_reg <= wgt_next;
        scale_reg <= scale_next;
        bend_reg <= bend_next;
        rend_reg <= rend_next;
        tmp_reg <= tmp_next;
        m_result_reg <= m_result_next;
    end

    assign m_valid = m_valid_reg;
    assign m_result_value = m_result_reg;

    `FBSD_ASSERT_IMP(a_done_in_op, fpu_done, in_op)
    `FBSD_ASSERT_NXT(a_accept_starts, s_valid && s_ready, state_reg == ST_PROD && !issued_reg)
    `FBSD_ASSERT_NXT(a_out_clears_row, out_load, row_sum_reg == 32'd0 && m_valid)
    `FBSD_ASSERT_NXT(a_scale_clears_block, state_reg == ST_SCALE && fpu_done, block_sum_reg == 32'd0)

endmodule

// File: hdl/fbsd_fpu.sv
module fbsd_fpu
    import fbsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  fpu_req_t    req,
    input  logic [31:0] opa,
    input  logic [31:0] opb,
    output logic        done,
    output logic [31:0] result
);

    // stage 1: multiply or align+add
    logic        sa, sb, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [7:0]  xa, xb, xa_eff, xb_eff;
    logic [23:0] ma, mb;
    logic signed [EXP_W-1:0] ea, eb;
    logic [47:0] prod;
    logic        swap, sub_op, s_big;
    logic [7:0]  x_big, x_small, d;
    logic [4:0]  dcl;
    logic [23:0] m_big, m_small;
    logic signed [EXP_W-1:0] e_big;
    logic [54:0] ext;
    logic [26:0] a27, b27;
    logic [27:0] sum28;
    fpu_s1_t     s1_next, s1_reg;
    logic        v1_reg, v2_reg, v3_reg;

    always_comb begin
        sa = opa[31];
        sb = opb[31];
        xa = opa[30:23];
        xb = opb[30:23];
        nan_a = (xa == 8'hff) && (opa[22:0] != 23'd0);
        nan_b = (xb == 8'hff) && (opb[22:0] != 23'd0);
        inf_a = (xa == 8'hff) && (opa[22:0] == 23'd0);
        inf_b = (xb == 8'hff) && (opb[22:0] == 23'd0);
        zero_a = (opa[30:0] == 31'd0);
        zero_b = (opb[30:0] == 31'd0);
        xa_eff = (xa == 8'd0) ? 8'd1 : xa;
        xb_eff = (xb == 8'd0) ? 8'd1 : xb;
        ma = {xa != 8'd0, opa[22:0]};
        mb = {xb != 8'd0, opb[22:0]};
        ea = $signed({3'b000, xa_eff}) - 11'sd150;
        eb = $signed({3'b000, xb_eff}) - 11'sd150;
        prod = ma * mb;

        swap = opb[30:0] > opa[30:0];
        sub_op = sa ^ sb;
        s_big = swap ? sb : sa;
        x_big = swap ? xb_eff : xa_eff;
        x_small = swap ? xa_eff : xb_eff;
        m_big = swap ? mb : ma;
        m_small = swap ? ma : mb;
        e_big = swap ? eb : ea;
        d = x_big - x_small;
        dcl = (d > 8'd28) ? 5'd28 : d[4:0];
        ext = {m_small, 3'b000, 28'd0} >> dcl;
        a27 = {m_big, 3'b000};
        b27 = {ext[54:29], ext[28] | (ext[27:0] != 28'd0)};
        sum28 = sub_op ? ({1'b0, a27} - {1'b0, b27}) : ({1'b0, a27} + {1'b0, b27});

        s1_next = '0;
        if (req.op == FPU_MUL) begin
            s1_next.sign = sa ^ sb;
            s1_next.lsb_exp = ea + eb;
            s1_next.mant = prod;
            if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
                s1_next.kind = KIND_NAN;
            end else if (inf_a || inf_b) begin
                s1_next.kind = KIND_INF;
            end else if (prod == 48'd0) begin
                s1_next.kind = KIND_ZERO;
            end else begin
                s1_next.kind = KIND_FIN;
            end
        end else begin
            s1_next.lsb_exp = e_big - 11'sd3;
            s1_next.mant = {20'd0, sum28};
            s1_next.sign = s_big;
            if (nan_a || nan_b || (inf_a && inf_b && sub_op)) begin
                s1_next.kind = KIND_NAN;
            end else if (inf_a || inf_b) begin
                s1_next.kind = KIND_INF;
                s1_next.sign = inf_a ? sa : sb;
            end else if (sum28 == 28'd0) begin
                s1_next.kind = KIND_ZERO;
                s1_next.sign = sub_op ? 1'b0 : sa;
            end else begin
                s1_next.kind = KIND_FIN;
            end
        end
    end

    // stage 2: leading one and target shift
    logic [5:0]              lead;
    logic signed [EXP_W-1:0] e_top, k_lsb, f_tmp;
    fpu_s2_t                 s2_next, s2_reg;

    always_comb begin
        lead = 6'd0;
        for (int i = 0; i < MANT_W; i++) begin
            if (s1_reg.mant[i]) begin
                lead = 6'(i);
            end
        end
        e_top = s1_reg.lsb_exp + $signed({5'd0, lead});
        k_lsb = e_top - 11'sd23;
        if (k_lsb < -11'sd149) begin
            k_lsb = -11'sd149;
        end
        f_tmp = k_lsb + 11'sd149;
        s2_next.kind = s1_reg.kind;
        s2_next.sign = s1_reg.sign;
        s2_next.field = f_tmp[8:0];
        s2_next.shift = k_lsb - s1_reg.lsb_exp;
        s2_next.mant = s1_reg.mant;
    end

    // stage 3: shift, round, pack
    logic [5:0]              rsh;
    logic signed [EXP_W-1:0] neg_sh;
    logic [97:0]             t98;
    logic [47:0]             q;
    logic                    g, st;
    logic [32:0]             pk, pr;
    logic [31:0]             res_next, res_reg;

    always_comb begin
        rsh = (s2_reg.shift > 11'sd50) ? 6'd50 : s2_reg.shift[5:0];
        neg_sh = -s2_reg.shift;
        t98 = {s2_reg.mant, 50'd0} >> rsh;
        if (s2_reg.shift[EXP_W-1]) begin
            q = s2_reg.mant << neg_sh[4:0];
            g = 1'b0;
            st = 1'b0;
        end else begin
            q = t98[97:50];
            g = t98[49];
            st = (t98[48:0] != 49'd0);
        end
        pk = {1'b0, s2_reg.field, 23'd0} + {9'd0, q[23:0]};
        pr = pk + {32'd0, g & (st | pk[0])};
        unique case (s2_reg.kind)
            KIND_NAN:  res_next = F32_QNAN;
            KIND_INF:  res_next = {s2_reg.sign, 8'hff, 23'd0};
            KIND_ZERO: res_next = {s2_reg.sign, 31'd0};
            KIND_FIN: begin
                if (pr >= 33'h0_7f80_0000) begin
                    res_next = {s2_reg.sign, 8'hff, 23'd0};
                end else begin
                    res_next = {s2_reg.sign, pr[30:0]};
                end
            end
            default: res_next = F32_QNAN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        res_reg <= res_next;
    end

    assign done = v3_reg;
    assign result = res_reg;

endmodule
